>>> hdl/csr_pkg.sv
// ----------------------------------------------------------------------------
// Complex square root package
// Control types shared by the cells of the root and divide chains.
// ----------------------------------------------------------------------------
`default_nettype none
package csr_pkg;

	typedef struct packed {
		logic adv;
		logic vld;
	} csr_step_t;

endpackage
`default_nettype wire

>>> hdl/csr_if.sv
// ----------------------------------------------------------------------------
// Complex square root stream interfaces
// Operand and result channels, each a word with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface csr_in_if #(parameter int W = 32) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] re_in;
	logic signed [W-1:0] im_in;
	modport source (output valid, re_in, im_in, input ready);
	modport sink   (input valid, re_in, im_in, output ready);
endinterface

interface csr_out_if #(parameter int W = 32) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] re_out;
	logic signed [W-1:0] im_out;
	modport source (output valid, re_out, im_out, input ready);
	modport sink   (input valid, re_out, im_out, output ready);
endinterface
`default_nettype wire

>>> hdl/csr_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of an integer square root: two radicand bits a cycle when the step advances.
// ----------------------------------------------------------------------------
`default_nettype none
module csr_sqrt_cell #(
	parameter int RW = 32,
	parameter int SW = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  csr_pkg::csr_step_t    step,
	input  wire  [2*RW-1:0]       rad_i,
	input  wire  [RW+1:0]         rem_i,
	input  wire  [RW-1:0]         root_i,
	input  wire  [SW-1:0]         side_i,
	output logic                  vld_o,
	output logic [2*RW-1:0]       rad_o,
	output logic [RW+1:0]         rem_o,
	output logic [RW-1:0]         root_o,
	output logic [SW-1:0]         side_o
);
	import csr_pkg::*;

	logic [RW+3:0] cur;
	logic [RW+3:0] trial;
	logic [RW+3:0] diff;
	logic          take;

	always_comb begin
		cur   = {rem_i, rad_i[2*RW-1 -: 2]};
		trial = {2'b00, root_i, 2'b01};
		diff  = cur - trial;
		take  = cur >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (step.adv) begin
			vld_o <= step.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (step.adv) begin
			rad_o  <= {rad_i[2*RW-3:0], 2'b00};
			rem_o  <= take ? diff[RW+1:0] : cur[RW+1:0];
			root_o <= {root_i[RW-2:0], take};
			side_o <= side_i;
		end
	end
endmodule
`default_nettype wire

>>> hdl/csr_div_cell.sv
// ----------------------------------------------------------------------------
// Divide cell
// One restoring step of an unsigned division: one quotient bit a cycle when the step advances.
// ----------------------------------------------------------------------------
`default_nettype none
module csr_div_cell #(
	parameter int NW = 48,
	parameter int DW = 26,
	parameter int SW = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  csr_pkg::csr_step_t    step,
	input  wire  [NW-1:0]         num_i,
	input  wire  [DW-1:0]         div_i,
	input  wire  [DW-1:0]         rem_i,
	input  wire  [NW-1:0]         quo_i,
	input  wire  [SW-1:0]         side_i,
	output logic                  vld_o,
	output logic [NW-1:0]         num_o,
	output logic [DW-1:0]         div_o,
	output logic [DW-1:0]         rem_o,
	output logic [NW-1:0]         quo_o,
	output logic [SW-1:0]         side_o
);
	import csr_pkg::*;

	logic [DW:0] cur;
	logic [DW:0] diff;
	logic        take;

	always_comb begin
		cur  = {rem_i, num_i[NW-1]};
		diff = cur - {1'b0, div_i};
		take = cur >= {1'b0, div_i};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (step.adv) begin
			vld_o <= step.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (step.adv) begin
			num_o  <= {num_i[NW-2:0], 1'b0};
			div_o  <= div_i;
			rem_o  <= take ? diff[DW-1:0] : cur[DW-1:0];
			quo_o  <= {quo_i[NW-2:0], take};
			side_o <= side_i;
		end
	end
endmodule
`default_nettype wire

>>> hdl/complex_square_root.sv
// ----------------------------------------------------------------------------
// Complex square root
// Principal square root of a signed fixed-point complex word.
// ----------------------------------------------------------------------------
// One word enters every cycle while the output is not stalled. The pipeline
// is built from three chains of cells: the modulus root, the second root and
// the restoring divider, each retiring one result bit per cell. The whole
// pipeline holds while a result waits at the output and is not taken.
`default_nettype none
module complex_square_root #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input wire        clk,
	input wire        arst_n,
	csr_in_if.sink    in_ch,
	csr_out_if.source out_ch
);
	import csr_pkg::*;

	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int H   = (W + 1) / 2;
	localparam int R2  = (W + F + 2) / 2;
	localparam int NW  = W + F;
	localparam int DW  = R2 + 1;
	localparam int CW  = (NW > R2) ? NW : R2;
	localparam int S1W = 2 * W + 2;
	localparam int S2W = W + 2;
	localparam int S3W = R2 + 2;

	logic adv;
	logic out_vld_q;
	logic [W-1:0] re_out_q, im_out_q;

	assign adv         = out_ch.ready || !out_vld_q;
	assign in_ch.ready = adv;

	// Magnitudes and signs.
	logic          vld_s1, neg_re_s1, neg_im_s1;
	logic [W-1:0]  re_s1, im_s1;
	logic [W-1:0]  re_raw, im_raw;

	assign re_raw = in_ch.re_in;
	assign im_raw = in_ch.im_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_re_s1 <= re_raw[W-1];
			neg_im_s1 <= im_raw[W-1];
			re_s1     <= re_raw[W-1] ? (~re_raw + W'(1)) : re_raw;
			im_s1     <= im_raw[W-1] ? (~im_raw + W'(1)) : im_raw;
		end
	end

	// Partial products of the squares.
	logic              vld_s2, neg_re_s2, neg_im_s2;
	logic [W-1:0]      re_s2, im_s2;
	logic [2*H-1:0]    rll_s2, ill_s2;
	logic [W-1:0]      rlh_s2, ilh_s2;
	logic [2*(W-H)-1:0] rhh_s2, ihh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_re_s2 <= neg_re_s1;
			neg_im_s2 <= neg_im_s1;
			re_s2     <= re_s1;
			im_s2     <= im_s1;
			rll_s2    <= re_s1[H-1:0] * re_s1[H-1:0];
			ill_s2    <= im_s1[H-1:0] * im_s1[H-1:0];
			rlh_s2    <= W'(re_s1[H-1:0]) * W'(re_s1[W-1:H]);
			ilh_s2    <= W'(im_s1[H-1:0]) * W'(im_s1[W-1:H]);
			rhh_s2    <= re_s1[W-1:H] * re_s1[W-1:H];
			ihh_s2    <= im_s1[W-1:H] * im_s1[W-1:H];
		end
	end

	// Sum of squares.
	logic           vld_s3;
	logic [2*W-1:0] sq_s3;
	logic [S1W-1:0] side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s3 <= ((2*W)'(rhh_s2) << (2*H)) + ((2*W)'(rlh_s2) << (H+1))
				+ (2*W)'(rll_s2) + ((2*W)'(ihh_s2) << (2*H))
				+ ((2*W)'(ilh_s2) << (H+1)) + (2*W)'(ill_s2);
			side_s3 <= {neg_re_s2, neg_im_s2, re_s2, im_s2};
		end
	end

	// Modulus root chain.
	logic           v1 [0:W];
	logic [2*W-1:0] rad1 [0:W];
	logic [W+1:0]   rem1 [0:W];
	logic [W-1:0]   root1 [0:W];
	logic [S1W-1:0] side1 [0:W];

	assign v1[0]    = vld_s3;
	assign rad1[0]  = sq_s3;
	assign rem1[0]  = '0;
	assign root1[0] = '0;
	assign side1[0] = side_s3;

	for (genvar i = 0; i < W; i++) begin : g_sq1
		csr_sqrt_cell #(.RW(W), .SW(S1W)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.step('{adv: adv, vld: v1[i]}),
			.rad_i(rad1[i]), .rem_i(rem1[i]), .root_i(root1[i]), .side_i(side1[i]),
			.vld_o(v1[i+1]), .rad_o(rad1[i+1]), .rem_o(rem1[i+1]),
			.root_o(root1[i+1]), .side_o(side1[i+1])
		);
	end

	// Radicand of the second root.
	logic            vld_s4;
	logic [2*R2-1:0] rad_s4;
	logic [S2W-1:0]  side_s4;
	logic [W:0]      msum;

	assign msum = {1'b0, root1[W]} + {1'b0, side1[W][2*W-1:W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= v1[W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s4  <= ((2*R2)'(msum) << F) >> 1;
			side_s4 <= {side1[W][S1W-1:S1W-2], side1[W][W-1:0]};
		end
	end

	// Second root chain.
	logic            v2 [0:R2];
	logic [2*R2-1:0] rad2 [0:R2];
	logic [R2+1:0]   rem2 [0:R2];
	logic [R2-1:0]   root2 [0:R2];
	logic [S2W-1:0]  side2 [0:R2];

	assign v2[0]    = vld_s4;
	assign rad2[0]  = rad_s4;
	assign rem2[0]  = '0;
	assign root2[0] = '0;
	assign side2[0] = side_s4;

	for (genvar i = 0; i < R2; i++) begin : g_sq2
		csr_sqrt_cell #(.RW(R2), .SW(S2W)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.step('{adv: adv, vld: v2[i]}),
			.rad_i(rad2[i]), .rem_i(rem2[i]), .root_i(root2[i]), .side_i(side2[i]),
			.vld_o(v2[i+1]), .rad_o(rad2[i+1]), .rem_o(rem2[i+1]),
			.root_o(root2[i+1]), .side_o(side2[i+1])
		);
	end

	// Divider chain: (|im| << F) / (2 * root).
	logic           v3 [0:NW];
	logic [NW-1:0]  num3 [0:NW];
	logic [DW-1:0]  div3 [0:NW];
	logic [DW-1:0]  rem3 [0:NW];
	logic [NW-1:0]  quo3 [0:NW];
	logic [S3W-1:0] side3 [0:NW];

	assign v3[0]    = v2[R2];
	assign num3[0]  = NW'(side2[R2][W-1:0]) << F;
	assign div3[0]  = {root2[R2], 1'b0};
	assign rem3[0]  = '0;
	assign quo3[0]  = '0;
	assign side3[0] = {side2[R2][S2W-1:S2W-2], root2[R2]};

	for (genvar i = 0; i < NW; i++) begin : g_div
		csr_div_cell #(.NW(NW), .DW(DW), .SW(S3W)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.step('{adv: adv, vld: v3[i]}),
			.num_i(num3[i]), .div_i(div3[i]), .rem_i(rem3[i]), .quo_i(quo3[i]),
			.side_i(side3[i]),
			.vld_o(v3[i+1]), .num_o(num3[i+1]), .div_o(div3[i+1]),
			.rem_o(rem3[i+1]), .quo_o(quo3[i+1]), .side_o(side3[i+1])
		);
	end

	// Saturation, sign and output register.
	localparam logic [CW-1:0] MAXC = (CW'(1) << (W-1)) - CW'(1);

	logic          f_re_neg, f_im_neg;
	logic [R2-1:0] f_root;
	logic [CW-1:0] root_c, quo_c;
	logic [W-1:0]  root_m, quo_m, im_mag_m;

	always_comb begin
		f_re_neg = side3[NW][S3W-1];
		f_im_neg = side3[NW][S3W-2];
		f_root   = side3[NW][R2-1:0];
		root_c   = CW'(f_root);
		quo_c    = CW'(quo3[NW]);
		root_m   = (root_c > MAXC) ? MAXC[W-1:0] : root_c[W-1:0];
		quo_m    = (quo_c > MAXC) ? MAXC[W-1:0] : quo_c[W-1:0];
		im_mag_m = f_re_neg ? root_m : quo_m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= v3[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (f_root == '0) begin
				re_out_q <= '0;
				im_out_q <= '0;
			end else begin
				re_out_q <= f_re_neg ? quo_m : root_m;
				im_out_q <= f_im_neg ? (~im_mag_m + W'(1)) : im_mag_m;
			end
		end
	end

	assign out_ch.valid  = out_vld_q;
	assign out_ch.re_out = re_out_q;
	assign out_ch.im_out = im_out_q;

	// The real part of a principal root is never negative.
	a_re_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !re_out_q[W-1])
		else $error("negative real part of root");

	// A stalled pipeline keeps its output word.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ch.ready) |=> (out_vld_q && $stable(re_out_q)
			&& $stable(im_out_q)))
		else $error("output word lost during stall");

	// A new result comes only from a valid final divider cell.
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(v3[NW]))
		else $error("result without a word in the divider");
endmodule
`default_nettype wire
